FILE: src/scd_pkg.sv
// Package for the symmetric chamfer distance block.
// Shared types and constants; no dependencies.
`default_nettype none
package scd_pkg;
  localparam logic [1:0] OP_LOAD_ONE = 2'd0;
  localparam logic [1:0] OP_LOAD_TWO = 2'd1;
  localparam logic [1:0] OP_COMPUTE  = 2'd2;
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int unsigned FIT_BITS = 43;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] x_coord;
    logic [15:0] y_coord;
  } cmd_t;
endpackage
`default_nettype wire

FILE: src/scd_front.sv
// Front end: input skid queue of commands for the chamfer engine; unused opcodes are dropped.
// Depends on scd_pkg.
`default_nettype none
module scd_front (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  scd_pkg::cmd_t  in_cmd_i,
  output logic           q_valid_o,
  input  wire            q_ready_i,
  output scd_pkg::cmd_t  q_cmd_o
);
  scd_pkg::cmd_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o && (in_cmd_i.opcode != scd_pkg::OP_UNUSED);
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: src/scd_back.sv
// Back end: point stores, two pair sweeps with running minima, means and result register.
// Depends on scd_pkg.
`default_nettype none
module scd_back #(
  parameter int MAX_POINTS = 256,
  parameter int COORD_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          q_valid_i,
  output logic                         q_ready_o,
  input  scd_pkg::cmd_t                q_cmd_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [scd_pkg::FIT_BITS-1:0] out_fit_o,
  output logic                         out_drop_o
);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = 2 * COORD_BITS + 1;
  localparam int SW = DW + CW;
  localparam int FW = scd_pkg::FIT_BITS;
  localparam int QW = (SW + 8 > FW) ? SW + 8 : FW + 1;

  localparam logic [2:0] S_IDLE = 3'd0, S_PAIR = 3'd1, S_DRAIN = 3'd2,
                         S_DIV = 3'd3, S_OUT = 3'd4;

  logic [2*COORD_BITS-1:0] p1_q [MAX_POINTS];
  logic [2*COORD_BITS-1:0] p2_q [MAX_POINTS];

  logic [2:0]      st_q;
  logic [CW-1:0]   n1_q, n2_q;
  logic            ovf_q;
  logic [AW-1:0]   i_q, j_q;
  logic            sel_q;
  logic [SW-1:0]   sum_q;
  logic [SW+8-1:0] rem_q;
  logic [SW+8-1:0] quo_q;
  logic [6:0]      bit_q;
  logic [FW:0]     acc_q;
  logic [FW-1:0]   fit_q;
  logic            ov_valid_q, ov_drop_q;

  // pair pipeline
  logic [2*COORD_BITS-1:0]    a_q, b_q;
  logic                       rv_q, rfst_q, rlst_q;
  logic                       dv_q, dfst_q, dlst_q;
  logic [DW-1:0]              dd_q, ddx, ddy, rmin_q, cand;
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS-1:0]      ax, ay;
  logic [2*COORD_BITS-1:0]    sqx, sqy;

  logic          i_last, j_last;
  logic          load_ok, load_one, load_two;
  logic [CW-1:0] ncur;
  logic [SW+8:0] rtry;
  logic [QW-1:0] quo_x;
  logic [FW-1:0] mean_s;

  assign q_ready_o = (st_q == S_IDLE)
                   && !(ov_valid_q && q_cmd_i.opcode == scd_pkg::OP_COMPUTE);
  assign load_ok  = q_valid_i && q_ready_o;
  assign load_one = load_ok && (q_cmd_i.opcode == scd_pkg::OP_LOAD_ONE)
                  && (n1_q < CW'(MAX_POINTS));
  assign load_two = load_ok && (q_cmd_i.opcode == scd_pkg::OP_LOAD_TWO)
                  && (n2_q < CW'(MAX_POINTS));
  assign out_valid_o = ov_valid_q;
  assign out_fit_o = fit_q;
  assign out_drop_o = ov_drop_q;

  always_ff @(posedge clk_i) begin
    if (load_one)
      p1_q[n1_q[AW-1:0]] <= {q_cmd_i.x_coord[COORD_BITS-1:0],
                             q_cmd_i.y_coord[COORD_BITS-1:0]};
    if (load_two)
      p2_q[n2_q[AW-1:0]] <= {q_cmd_i.x_coord[COORD_BITS-1:0],
                             q_cmd_i.y_coord[COORD_BITS-1:0]};
    a_q <= p1_q[i_q];
    b_q <= p2_q[j_q];
  end

  always_comb begin
    dx = $signed({a_q[2*COORD_BITS-1], a_q[2*COORD_BITS-1:COORD_BITS]})
       - $signed({b_q[2*COORD_BITS-1], b_q[2*COORD_BITS-1:COORD_BITS]});
    dy = $signed({a_q[COORD_BITS-1], a_q[COORD_BITS-1:0]})
       - $signed({b_q[COORD_BITS-1], b_q[COORD_BITS-1:0]});
    ax = dx[COORD_BITS] ? (~dx[COORD_BITS-1:0] + 1'b1) : dx[COORD_BITS-1:0];
    ay = dy[COORD_BITS] ? (~dy[COORD_BITS-1:0] + 1'b1) : dy[COORD_BITS-1:0];
    sqx = ax * ax;
    sqy = ay * ay;
    ddx = {1'b0, sqx};
    ddy = {1'b0, sqy};
    cand = (dfst_q || dd_q < rmin_q) ? dd_q : rmin_q;
  end

  assign i_last = (CW'(i_q) + 1'b1 == n1_q);
  assign j_last = (CW'(j_q) + 1'b1 == n2_q);
  assign ncur = sel_q ? n2_q : n1_q;
  assign rtry = {rem_q, quo_q[SW+8-1]} - {{(SW+9-CW){1'b0}}, ncur};
  assign quo_x = QW'(quo_q);
  assign mean_s = (|quo_x[QW-1:FW]) ? {FW{1'b1}} : quo_x[FW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; n1_q <= '0; n2_q <= '0; ovf_q <= 1'b0;
      i_q <= '0; j_q <= '0; sel_q <= 1'b0; rv_q <= 1'b0; dv_q <= 1'b0;
      ov_valid_q <= 1'b0; ov_drop_q <= 1'b0; fit_q <= '0;
      sum_q <= '0; rem_q <= '0; quo_q <= '0; bit_q <= '0; acc_q <= '0;
      rfst_q <= 1'b0; rlst_q <= 1'b0; dfst_q <= 1'b0; dlst_q <= 1'b0;
      dd_q <= '0; rmin_q <= '0;
    end else begin
      if (ov_valid_q && out_ready_i) ov_valid_q <= 1'b0;
      rv_q <= 1'b0;
      dv_q <= rv_q;
      dd_q <= ddx + ddy;
      dfst_q <= rfst_q; dlst_q <= rlst_q;
      if (dv_q) begin
        rmin_q <= cand;
        if (dlst_q) sum_q <= sum_q + SW'(cand);
      end
      unique case (st_q)
        S_IDLE: if (load_ok) begin
          unique case (q_cmd_i.opcode)
            scd_pkg::OP_LOAD_ONE:
              if (load_one) n1_q <= n1_q + 1'b1; else ovf_q <= 1'b1;
            scd_pkg::OP_LOAD_TWO:
              if (load_two) n2_q <= n2_q + 1'b1; else ovf_q <= 1'b1;
            default: begin
              if (n1_q == '0 || n2_q == '0) begin
                fit_q <= '0; ov_drop_q <= ovf_q; ov_valid_q <= 1'b1;
                n1_q <= '0; n2_q <= '0; ovf_q <= 1'b0;
              end else begin
                i_q <= '0; j_q <= '0; sel_q <= 1'b0; sum_q <= '0; acc_q <= '0;
                st_q <= S_PAIR;
              end
            end
          endcase
        end
        S_PAIR: begin
          rv_q <= 1'b1;
          if (!sel_q) begin
            rfst_q <= (j_q == '0); rlst_q <= j_last;
            if (j_last) begin
              j_q <= '0;
              if (i_last) begin
                i_q <= '0; st_q <= S_DRAIN;
              end else i_q <= i_q + 1'b1;
            end else j_q <= j_q + 1'b1;
          end else begin
            rfst_q <= (i_q == '0); rlst_q <= i_last;
            if (i_last) begin
              i_q <= '0;
              if (j_last) begin
                j_q <= '0; st_q <= S_DRAIN;
              end else j_q <= j_q + 1'b1;
            end else i_q <= i_q + 1'b1;
          end
        end
        S_DRAIN: if (!rv_q && !dv_q) begin
          quo_q <= {sum_q, 8'd0};
          rem_q <= '0; bit_q <= 7'(SW + 8); st_q <= S_DIV;
        end
        S_DIV: begin
          if (bit_q == '0) begin
            if (!sel_q) begin
              acc_q <= {1'b0, mean_s};
              sel_q <= 1'b1; sum_q <= '0; st_q <= S_PAIR;
            end else begin
              acc_q <= acc_q + {1'b0, mean_s}; st_q <= S_OUT;
            end
          end else begin
            bit_q <= bit_q - 1'b1;
            if (!rtry[SW+8]) begin
              rem_q <= rtry[SW+8-1:0]; quo_q <= {quo_q[SW+8-2:0], 1'b1};
            end else begin
              rem_q <= {rem_q[SW+8-2:0], quo_q[SW+8-1]};
              quo_q <= {quo_q[SW+8-2:0], 1'b0};
            end
          end
        end
        S_OUT: if (!ov_valid_q) begin
          fit_q <= acc_q[FW] ? {FW{1'b1}} : acc_q[FW-1:0];
          ov_drop_q <= ovf_q; ov_valid_q <= 1'b1;
          n1_q <= '0; n2_q <= '0; ovf_q <= 1'b0; st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: src/symmetric_chamfer_distance_top.sv
// Top level of the symmetric chamfer distance block.
// Depends on scd_pkg, scd_front and scd_back.
// A two-beat queue feeds the engine; loads keep flowing while a result waits,
// but a compute waits until the previous result is taken. The sum of minima is
// SW = 2*COORD_BITS + 1 + clog2(MAX_POINTS+1) bits wide (42 at the defaults).
// A compute with both sets filled sweeps the pairs twice at one pair per cycle,
// once keeping the running minimum of each set-one point and once of each
// set-two point, each sweep followed by a pipeline drain and a bit-serial divide
// by the set size. A compute with an empty set gives a zero result in the cycle
// after the engine takes it.
`default_nettype none
module symmetric_chamfer_distance_top #(
  parameter int MAX_POINTS = 256,
  parameter int COORD_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,  // x_coord[15:0], y_coord[31:16]
  input  wire  [1:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata   // fitness_q8[42:0], points_dropped[43], zero fill
);
  scd_pkg::cmd_t cmd, qcmd;
  logic qv, qr;
  logic [scd_pkg::FIT_BITS-1:0] fit;
  logic drop;

  assign cmd.opcode  = s_axis_tuser;
  assign cmd.x_coord = s_axis_tdata[15:0];
  assign cmd.y_coord = s_axis_tdata[31:16];

  scd_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_cmd_i(cmd),
    .q_valid_o(qv), .q_ready_i(qr), .q_cmd_o(qcmd)
  );

  scd_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .q_valid_i(qv), .q_ready_o(qr), .q_cmd_i(qcmd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_fit_o(fit), .out_drop_o(drop)
  );

  assign m_axis_tdata = {4'd0, drop, fit};
endmodule
`default_nettype wire

FILE: verif/symmetric_chamfer_distance_top_tb.sv
// Testbench for symmetric_chamfer_distance_top: streams point loads, computes and unused
// opcodes, predicts each compute result in a scoreboard class and checks output beats.
// Depends on scd_pkg and the block's RTL.
`default_nettype none
module symmetric_chamfer_distance_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_DEPTH = 256;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int ITEM_GOAL = 1700;

  typedef struct {
    logic [42:0] fitness;
    logic        dropped;
  } chamfer_result_t;

  class chamfer_scoreboard;
    logic signed [15:0] one_x[$], one_y[$], two_x[$], two_y[$];
    logic               overflow;
    chamfer_result_t    expected_q[$];
    int                 errors;

    function new();
      overflow = 1'b0;
      errors   = 0;
    endfunction

    function logic [63:0] mean_q8(logic [63:0] minima[$]);
      logic [63:0] sum, n;
      sum = 0;
      n   = minima.size();
      foreach (minima[i]) sum += minima[i];
      return ((sum / n) << 8) + (((sum % n) << 8) / n);
    endfunction

    function logic [63:0] sq_dist(logic signed [15:0] ax, logic signed [15:0] ay,
                                  logic signed [15:0] bx, logic signed [15:0] by);
      longint dx, dy;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return dx * dx + dy * dy;
    endfunction

    function void note_input(logic [1:0] op, logic [15:0] x, logic [15:0] y);
      logic [63:0]     min_one[$], min_two[$], d, m1, m2;
      chamfer_result_t res;
      if (op == scd_pkg::OP_LOAD_ONE || op == scd_pkg::OP_LOAD_TWO) begin
        if (op == scd_pkg::OP_LOAD_ONE) begin
          if (one_x.size() >= SET_DEPTH) overflow = 1'b1;
          else begin
            one_x.push_back(x);
            one_y.push_back(y);
          end
        end else begin
          if (two_x.size() >= SET_DEPTH) overflow = 1'b1;
          else begin
            two_x.push_back(x);
            two_y.push_back(y);
          end
        end
      end else if (op == scd_pkg::OP_COMPUTE) begin
        res.fitness = '0;
        res.dropped = overflow;
        if (one_x.size() != 0 && two_x.size() != 0) begin
          foreach (one_x[i]) min_one.push_back('1);
          foreach (two_x[j]) min_two.push_back('1);
          foreach (one_x[i]) begin
            foreach (two_x[j]) begin
              d = sq_dist(one_x[i], one_y[i], two_x[j], two_y[j]);
              if (d < min_one[i]) min_one[i] = d;
              if (d < min_two[j]) min_two[j] = d;
            end
          end
          m1 = mean_q8(min_one);
          m2 = mean_q8(min_two);
          res.fitness = (m1 + m2 > 64'h7FF_FFFF_FFFF) ? '1 : 43'(m1 + m2);
        end
        expected_q.push_back(res);
        one_x.delete();
        one_y.delete();
        two_x.delete();
        two_y.delete();
        overflow = 1'b0;
      end
    endfunction

    function void check_result(logic [47:0] data);
      chamfer_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: fitness_q8=%0d points_dropped=%0d",
               data[42:0], data[43]);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (data[42:0] !== exp_res.fitness) begin
        $error("fitness_q8 mismatch: expected %0d, actual %0d", exp_res.fitness, data[42:0]);
        errors++;
      end
      if (data[43] !== exp_res.dropped) begin
        $error("points_dropped mismatch: expected %0d, actual %0d", exp_res.dropped, data[43]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  chamfer_scoreboard sb = new();
  int     idle_mode = 0;  // 0 none, 1 sender, 2 receiver, 3 both
  int     items_sent = 0;
  longint cycles = 0;

  symmetric_chamfer_distance_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** symmetric_chamfer_distance_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    case (idle_mode)
      2: m_axis_tready <= ($urandom_range(99) >= 80);
      3: m_axis_tready <= ($urandom_range(99) >= 17);
      default: m_axis_tready <= 1'b1;
    endcase
  end

  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  task automatic send_beat(logic [1:0] op, logic [15:0] x, logic [15:0] y);
    logic ok;
    int   gap_pct;
    gap_pct = (idle_mode == 1) ? 80 : (idle_mode == 3) ? 17 : 0;
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {y, x};
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    sb.note_input(op, x, y);
    if (op != scd_pkg::OP_UNUSED) items_sent++;
  endtask

  function automatic logic [15:0] pick_coord(int style, logic [15:0] base);
    case (style)
      0: return 16'($urandom());
      1: return base + 16'($urandom_range(15)) - 16'd8;
      default: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
    endcase
  endfunction

  task automatic run_set_pair(int n_one, int n_two);
    int          style, left_one, left_two;
    logic [15:0] bx, by;
    style = $urandom_range(9) < 6 ? 0 : ($urandom_range(3) == 0 ? 2 : 1);
    bx = 16'($urandom());
    by = 16'($urandom());
    left_one = n_one;
    left_two = n_two;
    while (left_one + left_two > 0) begin
      if ($urandom_range(19) == 0)
        send_beat(scd_pkg::OP_UNUSED, 16'($urandom()), 16'($urandom()));
      if (left_two == 0 || (left_one > 0 && $urandom_range(1))) begin
        send_beat(scd_pkg::OP_LOAD_ONE, pick_coord(style, bx), pick_coord(style, by));
        left_one--;
      end else begin
        send_beat(scd_pkg::OP_LOAD_TWO, pick_coord(style, bx), pick_coord(style, by));
        left_two--;
      end
    end
    send_beat(scd_pkg::OP_COMPUTE, 16'($urandom()), 16'($urandom()));
  endtask

  initial begin
    int seq_n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(scd_pkg::OP_COMPUTE, 16'h0000, 16'h0000);
    send_beat(scd_pkg::OP_LOAD_ONE, 16'h8000, 16'h8000);
    send_beat(scd_pkg::OP_COMPUTE, 16'hFFFF, 16'hFFFF);
    send_beat(scd_pkg::OP_LOAD_TWO, 16'h1234, 16'h8765);
    send_beat(scd_pkg::OP_COMPUTE, 16'h0000, 16'h0000);
    send_beat(scd_pkg::OP_LOAD_ONE, 16'h8000, 16'h8000);
    send_beat(scd_pkg::OP_UNUSED, 16'hFFFF, 16'hFFFF);
    send_beat(scd_pkg::OP_LOAD_TWO, 16'h7FFF, 16'h7FFF);
    send_beat(scd_pkg::OP_LOAD_TWO, 16'h8000, 16'h7FFF);
    send_beat(scd_pkg::OP_COMPUTE, 16'h0000, 16'h0000);
    send_beat(scd_pkg::OP_LOAD_ONE, 16'hFFFF, 16'h0001);
    send_beat(scd_pkg::OP_LOAD_TWO, 16'hFFFF, 16'h0001);
    send_beat(scd_pkg::OP_LOAD_ONE, 16'h0000, 16'hFFFE);
    send_beat(scd_pkg::OP_LOAD_ONE, 16'h0003, 16'h0004);
    send_beat(scd_pkg::OP_LOAD_TWO, 16'h0000, 16'h0000);
    send_beat(scd_pkg::OP_COMPUTE, 16'h0000, 16'h0000);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);

    seq_n = 0;
    while (items_sent < ITEM_GOAL) begin
      idle_mode = (seq_n / 8) % 4;
      if (seq_n == 20) run_set_pair(SET_DEPTH, SET_DEPTH);
      else if (seq_n == 45) run_set_pair(SET_DEPTH + 3, 2);
      else if (seq_n == 70) run_set_pair(1, SET_DEPTH + 2);
      else if ($urandom_range(9) == 0) run_set_pair($urandom_range(1), $urandom_range(1));
      else if ($urandom_range(9) == 0) run_set_pair($urandom_range(40, 1), $urandom_range(40, 1));
      else run_set_pair($urandom_range(8, 1), $urandom_range(8, 1));
      seq_n++;
    end
    s_axis_tvalid <= 1'b0;
    idle_mode = 0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("** symmetric_chamfer_distance_top: PASSED **");
    end else begin
      $display("** symmetric_chamfer_distance_top: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
src/scd_pkg.sv
src/scd_front.sv
src/scd_back.sv
src/symmetric_chamfer_distance_top.sv
verif/symmetric_chamfer_distance_top_tb.sv
